// ===== rtl/core/bsm_pkg.sv =====
// bsm_pkg: shared types and constants for the bad-sector map core.
// No dependencies; imported by bad_sector_map_core and the bench (tb).
`default_nettype none

package bsm_pkg;

	// sector arithmetic width: covers the farthest cluster end (just under 2^24)
	localparam int SEC_W = 25;
	// config data port width: widest register (sector_total)
	localparam int CFG_W = 17;

	localparam logic [1:0] FUNC_MARK    = 2'd0;
	localparam logic [1:0] FUNC_TEST    = 2'd1;
	localparam logic [1:0] FUNC_CLUSTER = 2'd2;
	localparam logic [1:0] FUNC_SPLIT   = 2'd3;

	localparam logic [1:0] REG_SECTOR_TOTAL        = 2'd0;
	localparam logic [1:0] REG_SECTORS_PER_CLUSTER = 2'd1;
	localparam logic [1:0] REG_FIRST_DATA_SECTOR   = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] target;
		logic [5:0]  span;
	} bsm_in_t;

	typedef struct packed {
		logic        status;
		logic        is_bad;
		logic [16:0] run_start;
		logic [5:0]  run_length;
		logic        run_good;
		logic        last;
	} bsm_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/bad_sector_map_core.sv =====
// bad_sector_map_core: bad-sector bitmap with mark, sector test, cluster test, range split.
// Uses bsm_pkg and bsm_bitmap. Mark/test finish from the start state; cluster multiplies, then
// walks the cluster's bytes. Split gives one result per bad sector and one per good run, closing
// a good run cut short before the range end first; one result per cycle at best.
// One transaction in work at a time, paced by the single bitmap read port.
// Reset: async, clears the bitmap's MAP_BYTES bytes (8192 by default) in a sweep, no input taken.
`default_nettype none

module bad_sector_map_core #(
	parameter int unsigned MAX_SECTORS = 65536,
	parameter int unsigned MAX_SPAN    = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_index,
	input  logic [bsm_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bsm_pkg::bsm_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bsm_pkg::bsm_out_t         out_data
);

	import bsm_pkg::*;

	localparam int unsigned MAP_BYTES = (MAX_SECTORS + 7) / 8;
	localparam int unsigned AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int          PW        = SEC_W - 3;
	localparam logic [SEC_W-1:0] LIMIT    = SEC_W'(MAX_SECTORS);
	localparam logic [6:0]       SPAN_CAP = 7'(MAX_SPAN);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_START = 6'b000100,
		ST_CMUL  = 6'b001000,
		ST_CSCAN = 6'b010000,
		ST_SPLIT = 6'b100000
	} state_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [16:0] sector_total_q;
	logic [7:0]  spc_q;
	logic [15:0] fds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_total_q <= 17'd65536;
			spc_q          <= 8'd1;
			fds_q          <= 16'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SECTOR_TOTAL:        sector_total_q <= cfg_data;
				REG_SECTORS_PER_CLUSTER: spc_q          <= cfg_data[7:0];
				REG_FIRST_DATA_SECTOR:   fds_q          <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// usable sectors: the disk size clipped to what the map can hold
	logic [SEC_W-1:0] total_ext;
	logic [SEC_W-1:0] usable;
	assign total_ext = SEC_W'(sector_total_q);
	assign usable    = (total_ext > LIMIT) ? LIMIT : total_ext;

	// ---------------------------------------------------------------
	// Sequencer registers
	// ---------------------------------------------------------------
	state_t           state_q, state_d;
	logic [1:0]       func_q, func_d;
	logic [15:0]      tgt_q, tgt_d;
	logic [5:0]       span_q, span_d;
	logic [SEC_W-1:0] cur_q, cur_d;
	logic [SEC_W-1:0] end_q, end_d;
	logic [PW-1:0]    ptr_q, ptr_d;     // byte under the read register
	logic [SEC_W-1:0] run_start_q, run_start_d;
	logic             run_open_q, run_open_d;
	logic [23:0]      prod_q, prod_d;

	logic [7:0] rdata;
	logic       clr_busy;
	logic       map_we;
	logic [7:0] map_wdata;

	logic     out_valid_q;
	bsm_out_t out_q;
	logic     out_free;
	logic     emit;
	bsm_out_t res;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Bitmap RAM. The read address is the next pointer, so rdata always holds
	// the byte at ptr_q; a mark writes back in the same cycle it emits.
	bsm_bitmap #(
		.DEPTH (MAP_BYTES),
		.AW    (AW)
	) u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (ptr_d[AW-1:0]),
		.rd_data  (rdata),
		.wr_en    (map_we),
		.wr_addr  (ptr_q[AW-1:0]),
		.wr_data  (map_wdata),
		.clr_busy (clr_busy)
	);

	// ---------------------------------------------------------------
	// Byte window helpers shared by cluster scan and split
	// ---------------------------------------------------------------
	logic [SEC_W-1:0] base;
	logic [SEC_W-1:0] nxt_base;
	logic [SEC_W-1:0] end_rem;
	logic [SEC_W-1:0] use_rem;
	logic [2:0]       lo;
	logic [7:0]       hit_vec;      // bad bits inside [cur, end) of this byte
	logic [3:0]       good_cnt;     // run of good in-range sectors from cur in this byte

	assign base     = {ptr_q, 3'b000};
	assign nxt_base = base + SEC_W'(8);
	assign end_rem  = end_q - base;
	assign use_rem  = usable - base;
	assign lo       = cur_q[2:0];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hit_vec[i] = (3'(i) >= lo) && (SEC_W'(i) < end_rem) && rdata[7 - i];
		end
	end

	always_comb begin
		logic stop;
		stop     = 1'b0;
		good_cnt = '0;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) >= lo) begin
				if (!stop && !rdata[7 - i] && (SEC_W'(i) < end_rem)
					&& (SEC_W'(i) < use_rem)) begin
					good_cnt = good_cnt + 4'd1;
				end else begin
					stop = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Next-state logic
	// ---------------------------------------------------------------
	logic [SEC_W-1:0] tgt_sec;
	logic             tgt_in;
	logic [6:0]       span_eff;
	logic [SEC_W-1:0] from_sec;
	logic [SEC_W-1:0] to_sec;
	logic             cur_in;
	logic             cur_bad;
	logic [SEC_W-1:0] cur_inc;
	logic [SEC_W-1:0] adv;
	logic [SEC_W-1:0] good_from;

	assign tgt_sec   = SEC_W'(tgt_q);
	assign tgt_in    = tgt_sec < usable;
	assign span_eff  = ({1'b0, span_q} > SPAN_CAP) ? SPAN_CAP : {1'b0, span_q};
	assign from_sec  = SEC_W'(prod_q) + SEC_W'(fds_q);
	assign to_sec    = from_sec + SEC_W'(spc_q);
	assign cur_in    = cur_q < usable;
	assign cur_bad   = rdata[3'd7 - lo];
	assign cur_inc   = cur_q + SEC_W'(1);
	assign adv       = cur_q + SEC_W'(good_cnt);
	assign good_from = run_open_q ? run_start_q : cur_q;
	assign map_wdata = rdata | (8'h80 >> tgt_q[2:0]);

	always_comb begin
		state_d     = state_q;
		func_d      = func_q;
		tgt_d       = tgt_q;
		span_d      = span_q;
		cur_d       = cur_q;
		end_d       = end_q;
		ptr_d       = ptr_q;
		run_start_d = run_start_q;
		run_open_d  = run_open_q;
		prod_d      = prod_q;
		emit        = 1'b0;
		map_we      = 1'b0;
		res         = '0;
		res.last    = 1'b1;

		case (state_q)
			ST_CLEAR: begin
				if (!clr_busy) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (in_valid) begin
					func_d  = in_data.func;
					tgt_d   = in_data.target;
					span_d  = in_data.span;
					ptr_d   = PW'(in_data.target[15:3]);
					state_d = ST_START;
				end
			end

			ST_START: begin
				case (func_q)
					FUNC_MARK: begin
						if (out_free) begin
							emit       = 1'b1;
							res.status = !tgt_in;
							map_we     = tgt_in;
							state_d    = ST_IDLE;
						end
					end
					FUNC_TEST: begin
						if (out_free) begin
							emit       = 1'b1;
							res.status = !tgt_in;
							res.is_bad = !tgt_in || rdata[3'd7 - tgt_q[2:0]];
							state_d    = ST_IDLE;
						end
					end
					FUNC_CLUSTER: begin
						// clusters 0 and 1 do not exist
						if (tgt_q < 16'd2) begin
							if (out_free) begin
								emit       = 1'b1;
								res.status = 1'b1;
								res.is_bad = 1'b1;
								state_d    = ST_IDLE;
							end
						end else begin
							prod_d  = 24'(tgt_q - 16'd2) * 24'(spc_q);
							state_d = ST_CMUL;
						end
					end
					FUNC_SPLIT: begin
						if (span_eff == 7'd0) begin
							state_d = ST_IDLE;
						end else begin
							cur_d      = tgt_sec;
							end_d      = tgt_sec + SEC_W'(span_eff);
							run_open_d = 1'b0;
							state_d    = ST_SPLIT;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end

			ST_CMUL: begin
				if (spc_q == 8'd0) begin
					// empty cluster: nothing to find
					if (out_free) begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (to_sec > usable) begin
					if (out_free) begin
						emit       = 1'b1;
						res.status = 1'b1;
						res.is_bad = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cur_d   = from_sec;
					end_d   = to_sec;
					ptr_d   = from_sec[SEC_W-1:3];
					state_d = ST_CSCAN;
				end
			end

			ST_CSCAN: begin
				// stop at the first bad bit or at the cluster's last byte
				if ((|hit_vec) || (end_q <= nxt_base)) begin
					if (out_free) begin
						emit       = 1'b1;
						res.is_bad = |hit_vec;
						state_d    = ST_IDLE;
					end
				end else begin
					cur_d = nxt_base;
					ptr_d = ptr_q + PW'(1);
				end
			end

			ST_SPLIT: begin
				if (!cur_in || cur_bad) begin
					if (out_free) begin
						emit = 1'b1;
						if (run_open_q) begin
							// close the pending good run, revisit cur next cycle
							res.run_start  = 17'(run_start_q);
							res.run_length = 6'(cur_q - run_start_q);
							res.run_good   = 1'b1;
							res.last       = 1'b0;
							run_open_d     = 1'b0;
						end else begin
							res.status     = !cur_in;
							res.is_bad     = 1'b1;
							res.run_start  = 17'(cur_q);
							res.run_length = 6'd1;
							res.last       = (cur_inc == end_q);
							cur_d          = cur_inc;
							ptr_d          = cur_inc[SEC_W-1:3];
							if (cur_inc == end_q) begin
								state_d = ST_IDLE;
							end
						end
					end
				end else if (adv == end_q) begin
					if (out_free) begin
						emit           = 1'b1;
						res.run_start  = 17'(good_from);
						res.run_length = 6'(adv - good_from);
						res.run_good   = 1'b1;
						run_open_d     = 1'b0;
						state_d        = ST_IDLE;
					end
				end else begin
					// extend the good run across this byte
					run_start_d = good_from;
					run_open_d  = 1'b1;
					cur_d       = adv;
					ptr_d       = adv[SEC_W-1:3];
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			run_open_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			run_open_q <= run_open_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q      <= func_d;
		tgt_q       <= tgt_d;
		span_q      <= span_d;
		cur_q       <= cur_d;
		end_q       <= end_d;
		ptr_q       <= ptr_d;
		run_start_q <= run_start_d;
		prod_q      <= prod_d;
	end

	// ---------------------------------------------------------------
	// Output register: a result may wait here while the next transaction
	// is taken in
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready)
		else $error("transaction taken during bitmap clear");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrites one not yet taken");

	a_split_cur_below_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPLIT) |-> (cur_q < end_q))
		else $error("split walked past the range end");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |-> (state_q == ST_START && func_q == FUNC_MARK && tgt_in && !clr_busy))
		else $error("bitmap write outside an in-range mark");

	a_cscan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CSCAN) |-> (end_q <= usable && cur_q < end_q))
		else $error("cluster scan outside the usable sectors");

endmodule

`default_nettype wire

// ===== rtl/core/bsm_bitmap.sv =====
// bsm_bitmap: byte-wide bitmap RAM, one registered read and one write port,
// with a zeroing sweep after reset. Depends on nothing outside this file.
`default_nettype none

module bsm_bitmap #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	output logic          clr_busy
);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;

	// one byte cleared per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for bad_sector_map_core (mark, sector test, cluster test, split).
// Depends on bsm_pkg and the core RTL only; keeps its own copy of the bitmap and registers.
// Random valid/ready pacing on both channels; results are checked in order, field by field.
`default_nettype none

module tb;
	import bsm_pkg::*;

	localparam int MAP_SECTORS = 65536;
	localparam int SPAN_CAP    = 32;
	// No transaction on either channel for this many cycles means a hang. The clearing sweep after
	// reset dominates; per-transaction work, long gaps and stalls are far less.
	localparam int STALL_LIMIT = 30000;
	// Quiet cycles after the last result: covers a split with span zero still in work.
	localparam int SETTLE_CYCLES = 40;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [1:0]           cfg_index = REG_SECTOR_TOTAL;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	bsm_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	bsm_out_t             out_data;

	bad_sector_map_core #(
		.MAX_SECTORS(MAP_SECTORS),
		.MAX_SPAN   (SPAN_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: bitmap (one bit per sector) and registers
	// ------------------------------------------------------------------
	bit          sec_bad [0:MAP_SECTORS-1];
	int          cfg_total = 65536;
	int          cfg_spc   = 1;
	int          cfg_fds   = 0;

	bsm_in_t     request_q[$];   // requests waiting for the driver
	bsm_out_t    map_replies[$]; // replies owed by the block, oldest first
	bsm_out_t    due_reply;

	int          n_sent;         // requests put on the bus
	int          n_taken;        // request transactions completed
	bit          req_taken;      // set at the edge that accepts a request
	int          req_gap;        // idle cycles before the next request
	int          ready_hold;     // cycles out_ready stays low
	bit          jitter_on = 1'b1;
	int          win_lo;         // sector window where random traffic clusters
	int          fail_count;
	int          quiet_cycles;

	function automatic int usable_sectors();
		return (cfg_total > MAP_SECTORS) ? MAP_SECTORS : cfg_total;
	endfunction

	function automatic bit sector_ok(int s);
		return s < usable_sectors();
	endfunction

	function automatic bsm_out_t reply(bit st, bit bad, int start, int len, bit good, bit lst);
		bsm_out_t r;
		r.status     = st;
		r.is_bad     = bad;
		r.run_start  = start[16:0];
		r.run_length = len[5:0];
		r.run_good   = good;
		r.last       = lst;
		return r;
	endfunction

	// Applies one request to the shadow bitmap and queues the replies it owes.
	task automatic sector_map_apply(bsm_in_t cmd);
		int tgt, from, upto, cur, fin, r;
		bit hit;
		tgt = int'(cmd.target);
		case (cmd.func)
			FUNC_MARK: begin
				// out-of-range mark leaves the map alone
				if (!sector_ok(tgt))
					map_replies.push_back(reply(1, 0, 0, 0, 0, 1));
				else begin
					sec_bad[tgt] = 1'b1;
					map_replies.push_back(reply(0, 0, 0, 0, 0, 1));
				end
			end
			FUNC_TEST: begin
				if (!sector_ok(tgt))
					map_replies.push_back(reply(1, 1, 0, 0, 0, 1));
				else
					map_replies.push_back(reply(0, sec_bad[tgt], 0, 0, 0, 1));
			end
			FUNC_CLUSTER: begin
				// clusters 0 and 1 do not exist; a cluster running past the disk is bad
				from = (tgt - 2) * cfg_spc + cfg_fds;
				upto = from + cfg_spc;
				hit  = 1'b0;
				if (tgt < 2 || (cfg_spc != 0 && upto > usable_sectors()))
					map_replies.push_back(reply(1, 1, 0, 0, 0, 1));
				else begin
					// zero sectors per cluster covers nothing, so it is good
					for (int s = from; s < upto; s++)
						if (sec_bad[s])
							hit = 1'b1;
					map_replies.push_back(reply(0, hit, 0, 0, 0, 1));
				end
			end
			default: begin
				// split: span saturates, span zero owes nothing
				cur = tgt;
				fin = tgt + ((cmd.span > SPAN_CAP) ? SPAN_CAP : int'(cmd.span));
				while (cur < fin) begin
					if (!sector_ok(cur) || sec_bad[cur]) begin
						map_replies.push_back(reply(!sector_ok(cur), 1, cur, 1, 0, cur + 1 == fin));
						cur++;
					end else begin
						r = cur;
						while (r < fin && sector_ok(r) && !sec_bad[r])
							r++;
						map_replies.push_back(reply(0, 0, cur, r - cur, 1, r == fin));
						cur = r;
					end
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Reporting
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(string fname, logic [16:0] got, logic [16:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h (transaction %0d)",
				fname, got, want, n_taken));
	endtask

	// Pacing: mostly short gaps, a few long ones; none while jitter is off.
	function automatic int idle_span();
		int pick;
		if (!jitter_on)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents requests at the falling edge, holds until accepted
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (req_gap != 0) begin
				in_valid <= 1'b0;
				req_gap--;
			end else if (request_q.size() != 0) begin
				in_data  <= request_q.pop_front();
				in_valid <= 1'b1;
				n_sent++;
				req_gap = idle_span();
			end else
				in_valid <= 1'b0;
		end
		req_taken = 1'b0;
	end

	// Back-pressure on the result channel.
	always @(negedge clk) begin
		if (ready_hold != 0) begin
			out_ready <= 1'b0;
			ready_hold--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				ready_hold = idle_span();
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both channels at the rising edge, predict and check
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sector_map_apply(in_data);
			n_taken++;
			req_taken = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (map_replies.size() == 0)
				flag_mismatch($sformatf("result 0x%0h with nothing pending", out_data));
			else begin
				due_reply = map_replies.pop_front();
				check_field("status",     out_data.status,     due_reply.status);
				check_field("is_bad",     out_data.is_bad,     due_reply.is_bad);
				check_field("run_start",  out_data.run_start,  due_reply.run_start);
				check_field("run_length", out_data.run_length, due_reply.run_length);
				check_field("run_good",   out_data.run_good,   due_reply.run_good);
				check_field("last",       out_data.last,       due_reply.last);
			end
		end
		// watchdog: any transaction on either side counts as progress
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic bsm_in_t mk_req(logic [1:0] f, int t, int s);
		bsm_in_t r;
		r.func   = f;
		r.target = t[15:0];
		r.span   = s[5:0];
		return r;
	endfunction

	// Random request aimed at the current window, the disk end, or anywhere.
	function automatic bsm_in_t rand_request();
		bsm_in_t r;
		int pick, edge_s;
		pick = $urandom_range(0, 99);
		r.func = (pick < 30) ? FUNC_MARK : (pick < 50) ? FUNC_TEST :
			(pick < 70) ? FUNC_CLUSTER : FUNC_SPLIT;
		pick = $urandom_range(0, 99);
		if (r.func == FUNC_CLUSTER) begin
			if (pick < 75)
				r.target = 16'($urandom_range(0, 2 + 160 / ((cfg_spc == 0) ? 1 : cfg_spc)));
			else if (pick < 90 && cfg_spc != 0 && usable_sectors() > cfg_fds)
				r.target = 16'(2 + (usable_sectors() - cfg_fds) / cfg_spc
					- $urandom_range(0, 2));
			else
				r.target = 16'($urandom);
		end else begin
			edge_s = usable_sectors() + $urandom_range(0, 80) - 40;
			if (edge_s < 0)
				edge_s = 0;
			if (edge_s > 65535)
				edge_s = 65535;
			if (pick < 70)
				r.target = 16'(win_lo + $urandom_range(0, 159));
			else if (pick < 85)
				r.target = 16'(edge_s);
			else if (pick < 93)
				r.target = 16'($urandom);
			else
				r.target = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		end
		pick = $urandom_range(0, 99);
		if (pick < 70)
			r.span = 6'($urandom_range(1, SPAN_CAP));
		else if (pick < 78)
			r.span = '0;
		else if (pick < 88)
			r.span = 6'($urandom_range(SPAN_CAP + 1, 63));
		else
			r.span = 6'($urandom_range(0, 63));
		return r;
	endfunction

	// Wait until every request is taken and every reply seen, then let the core settle.
	task automatic drain();
		do
			@(negedge clk);
		while (request_q.size() != 0 || n_sent != n_taken || map_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all three registers on back-to-back cycles; the core is idle here.
	task automatic write_regs(int total, int spc, int fds);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SECTOR_TOTAL;
		cfg_data  <= total[CFG_W-1:0];
		@(negedge clk);
		cfg_index <= REG_SECTORS_PER_CLUSTER;
		cfg_data  <= CFG_W'(spc[7:0]);
		@(negedge clk);
		cfg_index <= REG_FIRST_DATA_SECTOR;
		cfg_data  <= CFG_W'(fds[15:0]);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_total = total & 32'h1FFFF;
		cfg_spc   = spc & 32'hFF;
		cfg_fds   = fds & 32'hFFFF;
	endtask

	initial begin
		int total, spc, fds;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset registers: 65536 sectors, 1 sector per cluster, data at 0.
		// The first transactions wait out the clearing sweep.
		request_q.push_back(mk_req(FUNC_TEST, 0, 0));       // clean map
		request_q.push_back(mk_req(FUNC_MARK, 0, 0));
		request_q.push_back(mk_req(FUNC_TEST, 0, 0));
		request_q.push_back(mk_req(FUNC_MARK, 65535, 63));  // last sector, all ones
		request_q.push_back(mk_req(FUNC_TEST, 65535, 0));
		request_q.push_back(mk_req(FUNC_MARK, 7, 0));       // last bit of a byte
		request_q.push_back(mk_req(FUNC_MARK, 9, 0));
		request_q.push_back(mk_req(FUNC_SPLIT, 0, 12));     // alternating runs
		request_q.push_back(mk_req(FUNC_SPLIT, 65530, 63)); // saturated span off the disk
		request_q.push_back(mk_req(FUNC_SPLIT, 5, 0));      // owes no reply
		request_q.push_back(mk_req(FUNC_CLUSTER, 0, 0));    // nonexistent clusters
		request_q.push_back(mk_req(FUNC_CLUSTER, 1, 0));
		request_q.push_back(mk_req(FUNC_CLUSTER, 2, 0));    // holds sector 0, bad
		request_q.push_back(mk_req(FUNC_CLUSTER, 65535, 0));
		request_q.push_back(mk_req(FUNC_SPLIT, 16'hAAAA, 1));
		drain();

		// Directed, small disk: 100 sectors, 4 per cluster, data at 10.
		write_regs(100, 4, 10);
		request_q.push_back(mk_req(FUNC_MARK, 99, 0));      // last usable sector
		request_q.push_back(mk_req(FUNC_MARK, 100, 0));     // just past the end
		request_q.push_back(mk_req(FUNC_TEST, 150, 0));
		request_q.push_back(mk_req(FUNC_MARK, 12, 0));
		request_q.push_back(mk_req(FUNC_CLUSTER, 2, 0));    // sectors 10..13
		request_q.push_back(mk_req(FUNC_CLUSTER, 24, 0));   // runs past sector 99
		request_q.push_back(mk_req(FUNC_CLUSTER, 23, 0));   // sectors 94..97
		request_q.push_back(mk_req(FUNC_SPLIT, 90, 20));    // crosses the disk end
		drain();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					total = 65536; spc = 1; fds = 0;
				end
				1: begin
					total = 32'h1FFFF; spc = 128; fds = 0;   // total above map size
				end
				2: begin
					total = 0; spc = 255; fds = 65535;       // every sector out of range
				end
				3: begin
					total = 300; spc = 0; fds = 20;          // empty clusters
				end
				4: begin
					total = $urandom_range(1, 65536);
					spc   = $urandom_range(1, 16);
					fds   = $urandom_range(0, total - 1);
				end
				default: begin
					total = 65536;
					spc   = $urandom_range(1, 8);
					fds   = $urandom_range(0, 65535);
				end
			endcase
			write_regs(total, spc, fds);
			win_lo = $urandom_range(0, 1) ? cfg_fds : usable_sectors() - 100;
			if (win_lo < 0)
				win_lo = 0;
			if (win_lo > 65535 - 160)
				win_lo = 65535 - 160;
			// one phase runs with both channels at full rate
			jitter_on = (ph != 3);
			repeat (40) request_q.push_back(rand_request());
			drain();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
